FILE: design/fdss_pkg.sv
`timescale 1ns / 1ps
package fdss_pkg;

  localparam int NUM_W    = 14;
  localparam int DIGIT_W  = 4;
  localparam int SEG_W    = 7;
  localparam int SEL_W    = 4;
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 16;

  localparam logic [NUM_W-1:0] MAX_NUMBER = 14'd9999;

  // reciprocal constants: floor(x * K >> S) equals x / D over the value range in use
  localparam logic [13:0] RECIP_1000 = 14'd8389;
  localparam int          SHIFT_1000 = 23;
  localparam logic [12:0] RECIP_100  = 13'd5243;
  localparam int          SHIFT_100  = 19;
  localparam logic [7:0]  RECIP_10   = 8'd205;
  localparam int          SHIFT_10   = 11;

  // one-hot digit selects
  localparam logic [SEL_W-1:0] SEL_ONES      = 4'd1;
  localparam logic [SEL_W-1:0] SEL_HUNDREDS  = 4'd2;
  localparam logic [SEL_W-1:0] SEL_TENS      = 4'd4;
  localparam logic [SEL_W-1:0] SEL_THOUSANDS = 4'd8;

  // frame slots in scan order
  localparam logic [1:0] FRAME_ONES      = 2'd0;
  localparam logic [1:0] FRAME_HUNDREDS  = 2'd1;
  localparam logic [1:0] FRAME_TENS      = 2'd2;
  localparam logic [1:0] FRAME_THOUSANDS = 2'd3;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [DIGIT_W-1:0] th;
    logic [DIGIT_W-1:0] hu;
    logic [DIGIT_W-1:0] te;
    logic [DIGIT_W-1:0] on;
  } digits_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  // bit0 segment a .. bit6 segment g
  function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0: s = 7'h3f;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5b;
      4'd3: s = 7'h4f;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6d;
      4'd6: s = 7'h7d;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7f;
      4'd9: s = 7'h6f;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

FILE: design/fdss_front.sv
`timescale 1ns / 1ps
module fdss_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [fdss_pkg::NUM_W-1:0]      in_number,
  input  fdss_pkg::q_status_t             q_stat,
  output logic                            push,
  output fdss_pkg::digits_t               push_data
);
  import fdss_pkg::*;

  logic [6:1] v;
  logic       en;

  // stage payloads
  logic [NUM_W-1:0]   n1;
  logic [27:0]        p1;
  logic [DIGIT_W-1:0] th2, th3, th4, th5, th6;
  logic [9:0]         r1_2, r1_3;
  logic [22:0]        p2;
  logic [DIGIT_W-1:0] hu4, hu5, hu6;
  logic [6:0]         r2_4, r2_5;
  logic [14:0]        p3;
  logic [DIGIT_W-1:0] te6, on6;

  logic [NUM_W-1:0]   nsat;
  logic [DIGIT_W-1:0] th_c, hu_c, te_c;
  logic [NUM_W-1:0]   r1_c;
  logic [9:0]         r2_c;
  logic [6:0]         on_c;

  assign en       = !v[6] || !q_stat.full;
  assign in_ready = en;
  assign push     = v[6] && !q_stat.full;
  assign push_data = '{th: th6, hu: hu6, te: te6, on: on6};

  always_comb begin
    nsat = (in_number > MAX_NUMBER) ? MAX_NUMBER : in_number;
    th_c = p1[SHIFT_1000 +: DIGIT_W];
    r1_c = n1 - NUM_W'(th_c) * NUM_W'(1000);
    hu_c = p2[SHIFT_100 +: DIGIT_W];
    r2_c = r1_3 - 10'(hu_c) * 10'd100;
    te_c = p3[SHIFT_10 +: DIGIT_W];
    on_c = r2_5 - 7'(te_c) * 7'd10;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1   <= nsat;
      p1   <= 28'(nsat) * 28'(RECIP_1000);
      th2  <= th_c;
      r1_2 <= r1_c[9:0];
      th3  <= th2;
      r1_3 <= r1_2;
      p2   <= 23'(r1_2) * 23'(RECIP_100);
      th4  <= th3;
      hu4  <= hu_c;
      r2_4 <= r2_c[6:0];
      th5  <= th4;
      hu5  <= hu4;
      r2_5 <= r2_4;
      p3   <= 15'(r2_4) * 15'(RECIP_10);
      th6  <= th5;
      hu6  <= hu5;
      te6  <= te_c;
      on6  <= 4'(on_c);
    end
  end

endmodule

FILE: design/fdss_fifo.sv
`timescale 1ns / 1ps
module fdss_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fdss_pkg::digits_t   push_data,
  input  logic                pop,
  output fdss_pkg::q_status_t q_stat,
  output fdss_pkg::digits_t   head
);
  import fdss_pkg::*;

  digits_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   cnt;

  assign q_stat.full      = (cnt == Q_CNT_W'(Q_DEPTH));
  assign q_stat.not_empty = (cnt != '0);
  assign head             = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: design/fdss_back.sv
`timescale 1ns / 1ps
module fdss_back (
  input  logic                          clk,
  input  logic                          rst,
  input  fdss_pkg::q_status_t           q_stat,
  input  fdss_pkg::digits_t             head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fdss_pkg::SEL_W-1:0]    out_sel,
  output logic [fdss_pkg::SEG_W-1:0]    out_seg,
  output logic                          out_last
);
  import fdss_pkg::*;

  logic [1:0]       idx;
  logic             ld;
  logic             blank_th, blank_hu, blank_te;
  logic [SEL_W-1:0] sel_c;
  logic [SEG_W-1:0] seg_c;
  logic             last_c;

  assign ld  = q_stat.not_empty && (!out_valid || out_ready);
  assign pop = ld && (idx == FRAME_THOUSANDS);

  // leading zero blanking, ones never blank
  assign blank_th = (head.th == '0);
  assign blank_hu = blank_th && (head.hu == '0);
  assign blank_te = blank_hu && (head.te == '0);

  always_comb begin
    sel_c  = SEL_ONES;
    seg_c  = seg_of(head.on);
    last_c = 1'b0;
    case (idx)
      FRAME_ONES: begin
        sel_c = SEL_ONES;
        seg_c = seg_of(head.on);
      end
      FRAME_HUNDREDS: begin
        sel_c = SEL_HUNDREDS;
        seg_c = blank_hu ? '0 : seg_of(head.hu);
      end
      FRAME_TENS: begin
        sel_c = SEL_TENS;
        seg_c = blank_te ? '0 : seg_of(head.te);
      end
      FRAME_THOUSANDS: begin
        sel_c  = SEL_THOUSANDS;
        seg_c  = blank_th ? '0 : seg_of(head.th);
        last_c = 1'b1;
      end
      default: begin
        sel_c = SEL_ONES;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= FRAME_ONES;
      out_valid <= 1'b0;
    end else begin
      if (ld) begin
        idx       <= idx + 1'b1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_sel  <= sel_c;
      out_seg  <= seg_c;
      out_last <= last_c;
    end
  end

endmodule

FILE: design/four_digit_seven_segment_scan_unit.sv
`timescale 1ns / 1ps
// four-digit seven-segment scan unit
// input stream: s_tdata[13:0] carries a number, values above 9999 show as 9999.
// output stream: four frames per number in the order ones, hundreds, tens,
//   thousands; each frame is a one-hot digit select and a segment pattern
//   (bit0 a .. bit6 g), the pattern zero where a leading zero is blanked.
//   m_tlast marks the thousands frame, the end of a scan pass.
// path: a number accepted on the input passes the six-stage digit split, the
//   queue write and the output register before its first frame shows on m_tvalid.
// throughput: one frame per cycle while the queue holds a number and m_tready
//   is high; each number puts four frames on the single output stream. the
//   split pipeline takes a new number every cycle while the queue has room,
//   so a short burst is absorbed before s_tready drops.
// stall: when m_tready is low the current frame holds on the port; the queue
//   fills, then the split pipeline stops and s_tready goes low.
// reset: rst (synchronous, active high) empties the pipeline and queue and
//   restarts the frame order at the ones digit; no frame is pending after it.
module four_digit_seven_segment_scan_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [13:0] number, [15:14] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [3:0] digit_select, [10:4] segments, [15:11] zero
  output logic        m_tlast
);
  import fdss_pkg::*;

  // front to queue
  logic       push;
  digits_t    push_data;
  // queue to back
  q_status_t  q_stat;
  digits_t    head;
  logic       pop;

  logic [SEL_W-1:0] out_sel;
  logic [SEG_W-1:0] out_seg;

  // saturation and digit split
  fdss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_number (s_tdata[NUM_W-1:0]),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // short queue of split numbers, decouples split from frame output
  fdss_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_stat    (q_stat),
    .head      (head)
  );

  // blanking, segment lookup and frame sequencing
  fdss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_sel   (out_sel),
    .out_seg   (out_seg),
    .out_last  (m_tlast)
  );

  assign m_tdata = {(M_DATA_W - SEL_W - SEG_W)'(0), out_seg, out_sel};

endmodule

FILE: design/fdss_checker.sv
`timescale 1ns / 1ps
module fdss_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);
  import fdss_pkg::*;

  // exactly one digit selected per frame
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot(m_tdata[SEL_W-1:0]))
    else $error("digit select not one-hot");

  // end of pass only on the thousands frame
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[SEL_W-1:0] == SEL_THOUSANDS)))
    else $error("tlast does not match thousands frame");

  // the ones digit is never blanked
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[SEL_W-1:0] == SEL_ONES) |-> (m_tdata[SEL_W +: SEG_W] != '0))
    else $error("ones digit blank");

  // a stalled frame holds
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled frame changed");

endmodule

bind four_digit_seven_segment_scan_unit fdss_checker u_fdss_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

FILE: tb/tb_four_digit_seven_segment_scan_unit.sv
`timescale 1ns / 1ps
import fdss_pkg::*;

// one digit frame as it leaves the block
typedef struct packed {
  logic [SEL_W-1:0] sel;
  logic [SEG_W-1:0] seg;
  logic             last;
} scan_frame_t;

class scan_scoreboard;
  scan_frame_t frames_due[$];
  int          mismatches;
  int          frames_seen;
  int          numbers_taken;
  int          numbers_clamped;

  function new();
    mismatches      = 0;
    frames_seen     = 0;
    numbers_taken   = 0;
    numbers_clamped = 0;
  endfunction

  function logic [SEG_W-1:0] glyph(int d, logic blank);
    logic [SEG_W-1:0] g;
    case (d)
      0: g = 7'h3f;
      1: g = 7'h06;
      2: g = 7'h5b;
      3: g = 7'h4f;
      4: g = 7'h66;
      5: g = 7'h6d;
      6: g = 7'h7d;
      7: g = 7'h07;
      8: g = 7'h7f;
      default: g = 7'h6f;
    endcase
    return blank ? '0 : g;
  endfunction

  // split the number, blank leading zeros, queue the four frames in scan order
  function void note_number(logic [NUM_W-1:0] n);
    int          v, th, hu, te, on;
    logic        blank_th, blank_hu, blank_te;
    scan_frame_t f;
    numbers_taken++;
    if (n > MAX_NUMBER) numbers_clamped++;
    v  = (n > MAX_NUMBER) ? int'(MAX_NUMBER) : int'(n);
    th = v / 1000;
    hu = (v / 100) % 10;
    te = (v / 10) % 10;
    on = v % 10;
    blank_th = (th == 0);
    blank_hu = blank_th && (hu == 0);
    blank_te = blank_hu && (te == 0);
    f = '{SEL_ONES,      glyph(on, 1'b0),     1'b0}; frames_due.push_back(f);
    f = '{SEL_HUNDREDS,  glyph(hu, blank_hu), 1'b0}; frames_due.push_back(f);
    f = '{SEL_TENS,      glyph(te, blank_te), 1'b0}; frames_due.push_back(f);
    f = '{SEL_THOUSANDS, glyph(th, blank_th), 1'b1}; frames_due.push_back(f);
  endfunction

  task report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task check_frame(logic [SEL_W-1:0] sel, logic [SEG_W-1:0] seg, logic last);
    scan_frame_t want;
    frames_seen++;
    if (frames_due.size() == 0) begin
      report($sformatf("unexpected frame sel=%h seg=%h last=%b", sel, seg, last));
    end else begin
      want = frames_due.pop_front();
      if (sel !== want.sel)
        report($sformatf("frame %0d select %h, want %h", frames_seen, sel, want.sel));
      if (seg !== want.seg)
        report($sformatf("frame %0d segments %h, want %h", frames_seen, seg, want.seg));
      if (last !== want.last)
        report($sformatf("frame %0d last %b, want %b", frames_seen, last, want.last));
    end
  endtask

  function int pending();
    return frames_due.size();
  endfunction
endclass

module tb_four_digit_seven_segment_scan_unit;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [13:0] number, [15:14] zero
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [3:0] digit_select, [10:4] segments, [15:11] zero
  logic        m_tlast;

  scan_scoreboard sb;

  // random idling on each side; cleared for the quiet stretch in the middle
  logic src_gaps;
  logic sink_stalls;

  four_digit_seven_segment_scan_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #4000000;
    $display("timeout with %0d frames still due", sb.pending());
    $display("status: fail");
    $finish;
  end

  // one input transfer; s_tvalid stays high from one number to the next when
  // no gap is drawn, so it never gets two assignments in one time step
  task automatic send_number(input logic [NUM_W-1:0] n);
    if (src_gaps) begin
      while ($urandom_range(99) < 33) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, n};
    do @(posedge clk); while (!s_tready);
    sb.note_number(n);
  endtask

  // hold the source off until every frame in flight has come out
  task automatic drain_frames();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // mix of ranges: mostly in range, some short numbers for blanking,
  // some above range for saturation
  function automatic logic [NUM_W-1:0] pick_number();
    int r;
    r = $urandom_range(99);
    if (r < 55)      return NUM_W'($urandom_range(9999));
    else if (r < 70) return NUM_W'($urandom_range(99));
    else if (r < 82) return NUM_W'($urandom_range(999, 100));
    else             return NUM_W'($urandom_range(16383, 10000));
  endfunction

  // sink side: sample the output transfer on the edge, then draw the next ready
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready)
        sb.check_frame(m_tdata[3:0], m_tdata[10:4], m_tlast);
      if (rst)
        m_tready <= 1'b0;
      else
        m_tready <= sink_stalls ? ($urandom_range(99) >= 33) : 1'b1;
    end
  end

  // directed numbers: all zero, each digit in the ones place, every blanking
  // depth, interior zeros, the top of range and saturated values up to all ones
  logic [NUM_W-1:0] edge_numbers [25] = '{
    14'd0,    14'd1,    14'd2,    14'd3,    14'd4,    14'd5,    14'd6,
    14'd7,    14'd8,    14'd9,    14'd10,   14'd99,   14'd100,  14'd105,
    14'd999,  14'd1000, 14'd1009, 14'd1200, 14'd5060, 14'd4321, 14'd8888,
    14'd9999, 14'd10000, 14'd12345, 14'd16383
  };

  initial begin
    sb          = new();
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (edge_numbers[i]) send_number(edge_numbers[i]);

    // random part with idling on both sides
    repeat (80) send_number(pick_number());

    // quiet stretch: full rate in, no stalls out
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    repeat (80) send_number(pick_number());

    // source waits for the output to run dry, then idling resumes
    drain_frames();
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    repeat (90) send_number(pick_number());

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // catch any stray frames after the last expected one
    repeat (24) @(posedge clk);

    $display("covered %0d numbers (%0d above range) and %0d digit frames",
             sb.numbers_taken, sb.numbers_clamped, sb.frames_seen);
    $display("with random gaps and stalls, a gap-free stretch and one full drain");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
